// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module of the FIR filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define ASSERT_ON_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Checked at every rising edge while reset is held.
`define ASSERT_IN_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) !rstn |-> prop) \
    else $error("%m: reset assertion failed");

`endif

// ===== src/firq15_pkg.sv =====
// Package with constants and types of the Q15 FIR filter.
package firq15_pkg;

  localparam int unsigned Taps      = 32;
  localparam int unsigned LineDepth = Taps - 1;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned AccW      = 32;
  localparam int unsigned QShift    = 15;
  localparam int unsigned CoefsPerGroup = 4;
  localparam int unsigned NumGroups = 8;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = CoefsPerGroup * SampleW;
  localparam int unsigned CountW    = $clog2(Taps);
  localparam int unsigned PartSize  = 8;
  localparam int unsigned NumParts  = (Taps + PartSize - 1) / PartSize;
  localparam int unsigned PadTaps   = NumParts * PartSize;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [AccW-1:0]    acc_t;

  typedef struct packed {
    logic vld;
    logic last;
  } stage_ctl_t;

endpackage

// ===== src/firq15_in_if.sv =====
// Input sample channel of the FIR filter.
interface firq15_in_if
  import firq15_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

// ===== src/firq15_out_if.sv =====
// Result channel of the FIR filter.
interface firq15_out_if
  import firq15_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t filtered;
  logic    last_result;

  modport source (output valid, output filtered, output last_result, input ready);
  modport sink (input valid, input filtered, input last_result, output ready);
endinterface

// ===== src/firq15_cfg_if.sv =====
// Coefficient register write channel of the FIR filter.
interface firq15_cfg_if
  import firq15_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/firq15_mac.sv =====
// Registered tap products and partial sums of the FIR filter.
module firq15_mac
  import firq15_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  stage_ctl_t ctl_i,
  input  sample_t    win_i  [Taps],
  input  sample_t    coef_i [Taps],
  output acc_t       part_o [NumParts],
  output stage_ctl_t ctl_o
);

  acc_t       prod_q [PadTaps];
  acc_t       part_d [NumParts];
  acc_t       part_q [NumParts];
  stage_ctl_t ctl_b_q;
  stage_ctl_t ctl_c_q;

  for (genvar t = 0; t < PadTaps; t++) begin : g_prod
    if (t < Taps) begin : g_used
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          prod_q[t] <= acc_t'(win_i[t]) * acc_t'(coef_i[t]);
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk_i) begin
        prod_q[t] <= '0;
      end
    end
  end

  // The sums wrap at the accumulator width; only bits below it reach the result.
  always_comb begin
    for (int p = 0; p < NumParts; p++) begin
      part_d[p] = '0;
      for (int k = 0; k < PartSize; k++) begin
        part_d[p] = part_d[p] + prod_q[p*PartSize + k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      part_q <= part_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_b_q <= '0;
      ctl_c_q <= '0;
    end else if (adv_i) begin
      ctl_b_q <= ctl_i;
      ctl_c_q <= ctl_b_q;
    end
  end

  assign part_o = part_q;
  assign ctl_o  = ctl_c_q;

endmodule

// ===== src/fir_filter_q15.sv =====
// Top level of the streaming Q15 FIR filter.
//
// Samples enter on in_i, one item per sample, with last_sample marking the
// end of a block. Results leave on out_o, one item per sample once a full
// window of 32 samples is present, so the first 31 samples of every block
// are stored without giving a result. Coefficients are written on cfg_i,
// four taps per 64-bit register, with tap 0 in the low bits of register 0.
// Writes to an index above 7 are ignored, and cfg_i is always ready.
// After its sample is accepted, a result passes the window capture, tap
// product and partial sum registers, and its final sum enters the output register.
// One sample is accepted in every cycle while out_o takes results.
// When out_o stalls with a result pending, the whole pipeline holds and
// in_i.ready drops in that cycle; nothing is lost or repeated.
// Reset clears the coefficients, the warm-up count and all valid flags.
module fir_filter_q15
  import firq15_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  firq15_in_if.sink    in_i,
  firq15_out_if.source out_o,
  firq15_cfg_if.sink   cfg_i
);

  localparam int unsigned GroupIdxW = $clog2(NumGroups);

  logic [CfgDataW-1:0] coef_q [NumGroups];
  sample_t             coef_tap [Taps];
  sample_t             dline_q [LineDepth];
  sample_t             win_d [Taps];
  sample_t             win_q [Taps];
  logic [CountW-1:0]   warm_q;
  stage_ctl_t          ctl_a_q;
  stage_ctl_t          ctl_c;
  acc_t                part [NumParts];
  acc_t                sum;
  logic                out_valid_q;
  sample_t             filtered_q;
  logic                last_q;
  logic                advance;
  logic                accept;
  logic                full;

  assign advance = !out_valid_q || out_o.ready;
  assign accept  = in_i.valid && advance;
  assign full    = (warm_q == CountW'(Taps - 1));

  assign in_i.ready  = advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < NumGroups; g++) begin
        coef_q[g] <= '0;
      end
    end else if (cfg_i.valid && (cfg_i.index < CfgIdxW'(NumGroups))) begin
      coef_q[cfg_i.index[GroupIdxW-1:0]] <= cfg_i.data;
    end
  end

  for (genvar t = 0; t < Taps; t++) begin : g_coef
    assign coef_tap[t] =
      coef_q[t / CoefsPerGroup][(t % CoefsPerGroup) * SampleW +: SampleW];
  end

  // The oldest sample of the window meets tap 0, the new sample the last tap.
  always_comb begin
    for (int i = 0; i < Taps - 1; i++) begin
      win_d[i] = dline_q[Taps - 2 - i];
    end
    win_d[Taps-1] = in_i.sample;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dline_q[0] <= in_i.sample;
      for (int i = 1; i < LineDepth; i++) begin
        dline_q[i] <= dline_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
    end else if (accept) begin
      if (in_i.last_sample) begin
        warm_q <= '0;
      end else if (!full) begin
        warm_q <= warm_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
    end else if (advance) begin
      ctl_a_q.vld  <= accept && full;
      ctl_a_q.last <= in_i.last_sample;
    end
  end

  firq15_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (advance),
    .ctl_i  (ctl_a_q),
    .win_i  (win_q),
    .coef_i (coef_tap),
    .part_o (part),
    .ctl_o  (ctl_c)
  );

  always_comb begin
    sum = '0;
    for (int p = 0; p < NumParts; p++) begin
      sum = sum + part[p];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= ctl_c.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && ctl_c.vld) begin
      filtered_q <= sum[QShift +: SampleW];
      last_q     <= ctl_c.last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.filtered    = filtered_q;
  assign out_o.last_result = last_q;

endmodule

// ===== src/firq15_chk.sv =====
// Port checker of the FIR filter and its bind to the top level.
`include "assert_macros.svh"

module firq15_chk
  import firq15_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input sample_t filtered_i,
  input logic    last_result_i
);

  `ASSERT_IN_RST(a_no_result_in_reset, clk_i, rst_ni, !out_valid_i)
  `ASSERT_ON_CLK(a_result_holds, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(filtered_i) && $stable(last_result_i))
  `ASSERT_ON_CLK(a_ready_when_free, clk_i, rst_ni, (!out_valid_i || out_ready_i) |-> in_ready_i)
  `ASSERT_ON_CLK(a_hold_when_stalled, clk_i, rst_ni, (out_valid_i && !out_ready_i) |-> !in_ready_i)

endmodule

bind fir_filter_q15 firq15_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .filtered_i    (out_o.filtered),
  .last_result_i (out_o.last_result)
);
